/* src/udiv_pkg.sv */
`default_nettype none

package udiv_pkg;

  localparam int unsigned DefaultWidth = 16;

endpackage

`default_nettype wire

/* src/udiv_in_if.sv */
`default_nettype none

interface udiv_in_if #(
  parameter int unsigned WIDTH = udiv_pkg::DefaultWidth
);

  logic             valid;
  logic             ready;
  logic [WIDTH-1:0] dividend;
  logic [WIDTH-1:0] divisor;

  modport source (output valid, output dividend, output divisor, input ready);
  modport sink (input valid, input dividend, input divisor, output ready);

endinterface

`default_nettype wire

/* src/udiv_out_if.sv */
`default_nettype none

interface udiv_out_if #(
  parameter int unsigned WIDTH = udiv_pkg::DefaultWidth
);

  logic             valid;
  logic             ready;
  logic [WIDTH-1:0] quotient;
  logic [WIDTH-1:0] remainder;

  modport source (output valid, output quotient, output remainder, input ready);
  modport sink (input valid, input quotient, input remainder, output ready);

endinterface

`default_nettype wire

/* src/udiv_cell.sv */
`default_nettype none

module udiv_cell #(
  parameter int unsigned WIDTH = udiv_pkg::DefaultWidth
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             valid_i,
  output      logic             ready_o,
  input  wire logic [WIDTH-1:0] rem_i,
  input  wire logic [WIDTH-1:0] nq_i,
  input  wire logic [WIDTH-1:0] div_i,
  output      logic             valid_o,
  input  wire logic             ready_i,
  output      logic [WIDTH-1:0] rem_o,
  output      logic [WIDTH-1:0] nq_o,
  output      logic [WIDTH-1:0] div_o
);

  // The nq word holds the dividend bits still to be consumed in its upper part
  // and the quotient bits found so far in its lower part.
  logic             valid_q;
  logic [WIDTH-1:0] rem_q, rem_d;
  logic [WIDTH-1:0] nq_q, nq_d;
  logic [WIDTH-1:0] div_q;
  logic [WIDTH-1:0] shifted;
  logic             carry;
  logic             qbit;

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    carry   = rem_i[WIDTH-1];
    shifted = {rem_i[WIDTH-2:0], nq_i[WIDTH-1]};
    qbit    = carry || (shifted >= div_i);
    rem_d   = qbit ? (shifted - div_i) : shifted;
    nq_d    = {nq_i[WIDTH-2:0], qbit};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      rem_q <= rem_d;
      nq_q  <= nq_d;
      div_q <= div_i;
    end
  end

  assign valid_o = valid_q;
  assign rem_o   = rem_q;
  assign nq_o    = nq_q;
  assign div_o   = div_q;

endmodule

`default_nettype wire

/* src/unsigned_restoring_divider_top.sv */
// Each accepted input beat passes through a row of WIDTH cells to its result
// beat, one restoring step per cell.
// Throughput: one division per cycle while the output side takes results; a
// cell stalls only while it holds a result the next one cannot take, so bubbles in the row are filled up.
// Reset clears the valid bit of every cell; data registers are not reset.
`default_nettype none

module unsigned_restoring_divider_top #(
  parameter int unsigned WIDTH = udiv_pkg::DefaultWidth
) (
  input wire logic  clk_i,
  input wire logic  rst_ni,
  udiv_in_if.sink   in_i,
  udiv_out_if.source out_o
);

  logic             valid[WIDTH+1];
  logic             ready[WIDTH+1];
  logic [WIDTH-1:0] rem[WIDTH+1];
  logic [WIDTH-1:0] nq[WIDTH+1];
  logic [WIDTH-1:0] div[WIDTH+1];

  assign valid[0]   = in_i.valid;
  assign in_i.ready = ready[0];
  assign rem[0]     = '0;
  assign nq[0]      = in_i.dividend;
  assign div[0]     = in_i.divisor;

  for (genvar k = 0; k < WIDTH; k++) begin : g_cell
    udiv_cell #(
      .WIDTH(WIDTH)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .valid_i(valid[k]),
      .ready_o(ready[k]),
      .rem_i  (rem[k]),
      .nq_i   (nq[k]),
      .div_i  (div[k]),
      .valid_o(valid[k+1]),
      .ready_i(ready[k+1]),
      .rem_o  (rem[k+1]),
      .nq_o   (nq[k+1]),
      .div_o  (div[k+1])
    );
  end

  assign out_o.valid     = valid[WIDTH];
  assign ready[WIDTH]    = out_o.ready;
  assign out_o.quotient  = nq[WIDTH];
  assign out_o.remainder = rem[WIDTH];

endmodule

`default_nettype wire

/* src/udiv_chk.sv */
`default_nettype none

module udiv_chk #(
  parameter int unsigned WIDTH = udiv_pkg::DefaultWidth
) (
  input wire logic             clk_i,
  input wire logic             rst_ni,
  input wire logic             in_valid_i,
  input wire logic             in_ready_i,
  input wire logic             out_valid_i,
  input wire logic             out_ready_i,
  input wire logic [WIDTH-1:0] quotient_i,
  input wire logic [WIDTH-1:0] remainder_i
);

  // With the last cell free, every cell in the row is free as well.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!out_valid_i || out_ready_i) |-> in_ready_i)
    else $error("input stalled although the output side can move");

  assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_i)
    else $error("result beat shown during reset");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> out_valid_i)
    else $error("result beat withdrawn before it was taken");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> ($stable(quotient_i) && $stable(remainder_i)))
    else $error("stalled result beat changed");

endmodule

bind unsigned_restoring_divider_top udiv_chk #(
  .WIDTH(WIDTH)
) u_udiv_chk (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_i.valid),
  .in_ready_i (in_i.ready),
  .out_valid_i(out_o.valid),
  .out_ready_i(out_o.ready),
  .quotient_i (out_o.quotient),
  .remainder_i(out_o.remainder)
);

`default_nettype wire
